FILE: rtl/pli_pkg.sv
// Shared types and constants for the piecewise-linear interpolation block.
// Holds the opcodes, the controller state and job codes, and the serial unit control struct.
// Depends on nothing.
package pli_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam logic [1:0] OP_LOAD      = 2'd0;
   localparam logic [1:0] OP_EVALUATE  = 2'd1;
   localparam logic [1:0] OP_INTEGRATE = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_DONE,
      ST_EV_SEL, ST_EV_Y, ST_EV_LO, ST_EV_HI, ST_EV_PREP,
      ST_MUL, ST_DIV, ST_EV_ADD, ST_EV_RET,
      ST_SEG_CHK, ST_SEG_LO, ST_SEG_HI_RD, ST_SEG_HI, ST_SEG_EV, ST_SEG_PREP,
      ST_ACC, ST_FIN1, ST_FIN2, ST_OUT
   } state_type;

   // what the current search or evaluation is for
   typedef enum logic [2:0] {
      J_EVAL, J_S1, J_S2, J_XE, J_XS
   } job_type;

   typedef struct packed {
      logic start;
      logic divide;
   } md_ctrl_type;

endpackage

FILE: rtl/pli_serial_md.sv
// Shared shift-add multiplier (64 x 34, modulo 2^64) and restoring divider (64 / 34).
// One bit per cycle. Depends on pli_pkg.
module pli_serial_md (
   input  logic                 clock,
   input  logic                 reset,
   input  pli_pkg::md_ctrl_type ctrl,
   input  logic [63:0]          opnd_a,
   input  logic [33:0]          opnd_b,
   output logic                 done,
   output logic [63:0]          result
);
   import pli_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [33:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [33:0] rem_ff, rem_in;
   logic [33:0] trial;

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], a_ff[63]};
      if (ctrl.start) begin
         busy_in = 1'b1;
         div_in  = ctrl.divide;
         cnt_in  = ctrl.divide ? 7'd63 : 7'd33;
         a_in    = opnd_a;
         b_in    = opnd_b;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (trial >= b_ff) begin
               rem_in = trial - b_ff;
               a_in   = {a_ff[62:0], 1'b1};
            end else begin
               rem_in = trial;
               a_in   = {a_ff[62:0], 1'b0};
            end
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[62:0], 1'b0};
            b_in = {1'b0, b_ff[33:1]};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? a_ff : acc_ff;

endmodule

FILE: rtl/piecewise_linear_interp_integral.sv
// Top level: breakpoint memories, search and evaluate sequencer, trapezoid integrator.
// Depends on pli_pkg and pli_serial_md.
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | opcode, point_index, point_x/y, query_start/end
// rsp     | out       | rsp_valid / rsp_ready | result_value, empty_table_error
// csr     | in        | csr_wr_en             | csr_wr_data (point_count)
//
// Flow: a load writes both memories when accepted. An evaluate scans the breakpoints and, when it
// interpolates, runs a serial multiply and then a serial divide on the one shared shift/subtract
// unit. An integrate runs two searches, then per segment reads its bounds, runs two evaluates, a
// multiply and an accumulate.
// Reset: synchronous, clears the controller, point_count and the result valid; memories are not
// cleared. One item is worked at a time; a new item is taken while a result waits on rsp.
module piecewise_linear_interp_integral #(
   parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_point_index,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_query_start,
   input  logic signed [31:0] req_query_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_result_value,
   output logic               rsp_empty_table_error,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);
   import pli_pkg::*;

   localparam int IDXW = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);

   // breakpoint stores, one read port each, registered read data
   logic signed [31:0] mem_x [MAX_POINTS];
   logic signed [31:0] mem_y [MAX_POINTS];
   logic signed [31:0] x_rd_ff, y_rd_ff;
   logic [IDXW-1:0]    x_raddr, y_raddr;
   logic               mem_we;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic [4:0]          count_ff;
   logic [CW-1:0]       n_pts;
   logic                req_xfer;

   logic signed [31:0] q_ff, q_in, v1_ff, v1_in, v2_ff, v2_in;
   logic signed [31:0] xhi_ff, xhi_in, xlo_ff, xlo_in, ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic signed [31:0] xs_ff, xs_in, xe_ff, xe_in;
   logic [CW-1:0]      s_ff, s_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [CW:0]        seg_ff, seg_in;
   logic [CW-1:0]      s_m1, seg_m1;
   logic [32:0]        dx_ff, dx_in;
   logic               dyneg_ff, dyneg_in, neg_ff, neg_in, mul_int_ff, mul_int_in;
   logic [63:0]        hsum_ff, hsum_in, ev_res_ff, ev_res_in, res_ff, res_in;
   logic               err_ff, err_in;
   logic [127:0]       acc_ff, acc_in, mag_ff, mag_in;
   logic               sign_ff, sign_in;

   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_err_ff, rsp_err_in, rsp_valid_ff, rsp_valid_in;

   md_ctrl_type md_ctrl;
   logic [63:0] md_a, md_result;
   logic [33:0] md_b;
   logic        md_done;

   logic        direct_hit, out_load;
   logic [32:0] dy33, absdy, t33, w33, absw;
   logic [63:0] absh, sy;
   logic [126:0] half;

   assign n_pts    = (int'(count_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign mem_we   = req_xfer && (req_opcode == OP_LOAD) && (int'(req_point_index) < MAX_POINTS);
   assign s_m1     = s_ff - CW'(1);
   assign seg_m1   = CW'(seg_ff - (CW+1)'(1));
   // boundary cases: below first point, past last point, exact hit
   assign direct_hit = (s_ff == '0) || (s_ff == n_pts) || (q_ff == xhi_ff);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   assign dy33  = {yhi_ff[31], yhi_ff} - {ylo_ff[31], ylo_ff};
   assign absdy = dy33[32] ? -dy33 : dy33;
   assign t33   = {q_ff[31], q_ff} - {xlo_ff[31], xlo_ff};
   assign w33   = {xe_ff[31], xe_ff} - {xs_ff[31], xs_ff};
   assign absw  = w33[32] ? -w33 : w33;
   assign absh  = hsum_ff[63] ? -hsum_ff : hsum_ff;
   assign sy    = {{32{ylo_ff[31]}}, ylo_ff};
   assign half  = mag_ff[127:1];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[IDXW'(req_point_index)] <= req_point_x;
         mem_y[IDXW'(req_point_index)] <= req_point_y;
      end
      x_rd_ff <= mem_x[x_raddr];
      y_rd_ff <= mem_y[y_raddr];
   end

   pli_serial_md u_md (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .opnd_a (md_a),
      .opnd_b (md_b),
      .done   (md_done),
      .result (md_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_opcode == OP_EVALUATE || req_opcode == OP_INTEGRATE)) begin
               state_in = (n_pts == '0) ? ST_OUT : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:   state_in = (s_ff == n_pts) ? ST_SCAN_DONE : ST_SCAN_CHK;
         ST_SCAN_CHK:  state_in = (q_ff <= x_rd_ff) ? ST_SCAN_DONE : ST_SCAN_RD;
         ST_SCAN_DONE: begin
            case (job_ff)
               J_S1:    state_in = ST_SCAN_RD;
               J_S2:    state_in = ST_SEG_CHK;
               default: state_in = ST_EV_SEL;
            endcase
         end
         ST_EV_SEL:   state_in = direct_hit ? ST_EV_Y : ST_EV_LO;
         ST_EV_Y:     state_in = ST_EV_RET;
         ST_EV_LO:    state_in = ST_EV_HI;
         ST_EV_HI:    state_in = ST_EV_PREP;
         ST_EV_PREP:  state_in = ST_MUL;
         ST_MUL: begin
            if (md_done) begin
               state_in = mul_int_ff ? ST_ACC : ST_DIV;
            end
         end
         ST_DIV:      state_in = md_done ? ST_EV_ADD : ST_DIV;
         ST_EV_ADD:   state_in = ST_EV_RET;
         ST_EV_RET: begin
            case (job_ff)
               J_XE:    state_in = ST_SCAN_RD;
               J_XS:    state_in = ST_SEG_PREP;
               default: state_in = ST_OUT;
            endcase
         end
         ST_SEG_CHK: begin
            if (seg_ff > {1'b0, s2_ff}) begin
               state_in = ST_FIN1;
            end else if (seg_ff != '0) begin
               state_in = ST_SEG_LO;
            end else begin
               state_in = ST_SEG_HI_RD;
            end
         end
         ST_SEG_LO:    state_in = ST_SEG_HI_RD;
         ST_SEG_HI_RD: state_in = (seg_ff < {1'b0, n_pts}) ? ST_SEG_HI : ST_SEG_EV;
         ST_SEG_HI:    state_in = ST_SEG_EV;
         ST_SEG_EV:    state_in = ST_SCAN_RD;
         ST_SEG_PREP:  state_in = ST_MUL;
         ST_ACC:       state_in = ST_SEG_CHK;
         ST_FIN1:      state_in = ST_FIN2;
         ST_FIN2:      state_in = ST_OUT;
         ST_OUT:       state_in = out_load ? ST_IDLE : ST_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // memory addresses and serial unit control
   always_comb begin
      x_raddr        = s_ff[IDXW-1:0];
      y_raddr        = s_ff[IDXW-1:0];
      md_ctrl.start  = 1'b0;
      md_ctrl.divide = 1'b0;
      md_a           = {31'd0, absdy};
      md_b           = {1'b0, t33};
      case (state_ff)
         ST_EV_SEL: begin
            if (s_ff == n_pts) begin
               y_raddr = s_m1[IDXW-1:0];
            end else if (!direct_hit) begin
               x_raddr = s_m1[IDXW-1:0];
               y_raddr = s_m1[IDXW-1:0];
            end
         end
         ST_SEG_CHK:   x_raddr = seg_m1[IDXW-1:0];
         ST_SEG_HI_RD: x_raddr = seg_ff[IDXW-1:0];
         ST_EV_PREP:   md_ctrl.start = 1'b1;
         ST_SEG_PREP: begin
            md_ctrl.start = 1'b1;
            md_a          = absh;
            md_b          = {1'b0, absw};
         end
         ST_MUL: begin
            // quotient of the interpolation product by the x step
            if (md_done && !mul_int_ff) begin
               md_ctrl.start  = 1'b1;
               md_ctrl.divide = 1'b1;
               md_a           = md_result;
               md_b           = {1'b0, dx_ff};
            end
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      job_in = job_ff;   q_in = q_ff;     v1_in = v1_ff;   v2_in = v2_ff;
      xhi_in = xhi_ff;   xlo_in = xlo_ff; ylo_in = ylo_ff; yhi_in = yhi_ff;
      xs_in = xs_ff;     xe_in = xe_ff;   s_in = s_ff;     s1_in = s1_ff;
      s2_in = s2_ff;     seg_in = seg_ff; dx_in = dx_ff;   dyneg_in = dyneg_ff;
      neg_in = neg_ff;   mul_int_in = mul_int_ff;          hsum_in = hsum_ff;
      ev_res_in = ev_res_ff; res_in = res_ff; err_in = err_ff;
      acc_in = acc_ff;   mag_in = mag_ff; sign_in = sign_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               v1_in  = req_query_start;
               v2_in  = req_query_end;
               q_in   = req_query_start;
               s_in   = '0;
               job_in = (req_opcode == OP_INTEGRATE) ? J_S1 : J_EVAL;
               acc_in = '0;
               res_in = '0;
               err_in = 1'b1;
            end
         end
         ST_SCAN_CHK: begin
            if (q_ff <= x_rd_ff) begin
               xhi_in = x_rd_ff;
            end else begin
               s_in = s_ff + CW'(1);
            end
         end
         ST_SCAN_DONE: begin
            if (job_ff == J_S1) begin
               s1_in  = s_ff;
               q_in   = v2_ff;
               s_in   = '0;
               job_in = J_S2;
            end else if (job_ff == J_S2) begin
               s2_in  = s_ff;
               seg_in = {1'b0, s1_ff};
            end
         end
         ST_EV_Y:   ev_res_in = {{32{y_rd_ff[31]}}, y_rd_ff};
         ST_EV_LO: begin
            xlo_in = x_rd_ff;
            ylo_in = y_rd_ff;
         end
         ST_EV_HI:  yhi_in = y_rd_ff;
         ST_EV_PREP: begin
            dx_in      = {xhi_ff[31], xhi_ff} - {xlo_ff[31], xlo_ff};
            dyneg_in   = dy33[32];
            mul_int_in = 1'b0;
         end
         ST_EV_ADD: ev_res_in = dyneg_ff ? sy - md_result : sy + md_result;
         ST_EV_RET: begin
            case (job_ff)
               J_XE: begin
                  hsum_in = ev_res_ff;
                  q_in    = xs_ff;
                  s_in    = '0;
                  job_in  = J_XS;
               end
               J_XS: hsum_in = hsum_ff + ev_res_ff;
               default: begin
                  res_in = ev_res_ff;
                  err_in = 1'b0;
               end
            endcase
         end
         ST_SEG_CHK: begin
            xs_in = v1_ff;
            xe_in = v2_ff;
         end
         ST_SEG_LO: begin
            if (x_rd_ff > v1_ff) begin
               xs_in = x_rd_ff;
            end
         end
         ST_SEG_HI: begin
            if (x_rd_ff < v2_ff) begin
               xe_in = x_rd_ff;
            end
         end
         ST_SEG_EV: begin
            q_in   = xe_ff;
            s_in   = '0;
            job_in = J_XE;
         end
         ST_SEG_PREP: begin
            mul_int_in = 1'b1;
            neg_in     = w33[32] ^ hsum_ff[63];
         end
         ST_ACC: begin
            acc_in = neg_ff ? acc_ff - {64'd0, md_result} : acc_ff + {64'd0, md_result};
            seg_in = seg_ff + (CW+1)'(1);
         end
         ST_FIN1: begin
            sign_in = acc_ff[127];
            mag_in  = acc_ff[127] ? -acc_ff : acc_ff;
         end
         ST_FIN2: begin
            // halve toward zero, saturate to 64 bits
            err_in = 1'b0;
            if (sign_ff) begin
               if (half[126:64] != '0 || (half[63] && half[62:0] != '0)) begin
                  res_in = 64'h8000_0000_0000_0000;
               end else begin
                  res_in = -half[63:0];
               end
            end else if (half[126:63] != '0) begin
               res_in = 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
               res_in = half[63:0];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_value_in = res_ff;
         rsp_err_in   = err_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
      job_ff <= job_in;   q_ff <= q_in;     v1_ff <= v1_in;   v2_ff <= v2_in;
      xhi_ff <= xhi_in;   xlo_ff <= xlo_in; ylo_ff <= ylo_in; yhi_ff <= yhi_in;
      xs_ff <= xs_in;     xe_ff <= xe_in;   s_ff <= s_in;     s1_ff <= s1_in;
      s2_ff <= s2_in;     seg_ff <= seg_in; dx_ff <= dx_in;   dyneg_ff <= dyneg_in;
      neg_ff <= neg_in;   mul_int_ff <= mul_int_in;           hsum_ff <= hsum_in;
      ev_res_ff <= ev_res_in; res_ff <= res_in; err_ff <= err_in;
      acc_ff <= acc_in;   mag_ff <= mag_in; sign_ff <= sign_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_value      = rsp_value_ff;
   assign rsp_empty_table_error = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_table_error) |-> (rsp_result_value == '0))
      else $error("empty-table transfer with nonzero value");

   a_md_done_state: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == ST_MUL || state_ff == ST_DIV))
      else $error("serial unit finished outside multiply or divide");

   a_seg_lo: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG_LO) |-> (seg_ff != '0) && $past(state_ff == ST_SEG_CHK))
      else $error("lower breakpoint read for first segment");

endmodule

FILE: sim/piecewise_linear_interp_integral_tb.sv
// Testbench for piecewise_linear_interp_integral: table loads, evaluates, integrates.
// Directed table first, then random tables and queries, checked against an in-bench predictor.
// Depends on pli_pkg and the block under test; reads no files.
module piecewise_linear_interp_integral_tb;
   import pli_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS       = 16;
   localparam int IDLE_LIMIT = 40000;  // an integrate can span 17 segments
   localparam logic [1:0] OP_NONE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_opcode = OP_NONE;
   logic [3:0]         req_point_index = '0;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_query_start = '0;
   logic signed [31:0] req_query_end = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [63:0] rsp_result_value;
   logic               rsp_empty_table_error;
   logic               csr_wr_en = 1'b0;
   logic [4:0]         csr_wr_data = '0;

   piecewise_linear_interp_integral u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_point_index       (req_point_index),
      .req_point_x           (req_point_x),
      .req_point_y           (req_point_y),
      .req_query_start       (req_query_start),
      .req_query_end         (req_query_end),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_value      (rsp_result_value),
      .rsp_empty_table_error (rsp_empty_table_error),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: mirror of the breakpoint table and the point_count register
   // ---------------------------------------------------------------------
   typedef struct {
      logic [63:0] value;
      logic        empty_err;
   } result_type;

   longint      tbl_x [NPTS];
   longint      tbl_y [NPTS];
   logic [4:0]  point_count_m;
   result_type  pending_results [$];
   int          fail_count = 0;
   bit          quiet = 1'b0;  // phase with no idling on either side

   function automatic int used_points();
      return (point_count_m > NPTS) ? NPTS : int'(point_count_m);
   endfunction

   // first valid slot whose x is at or above v; n when none
   function automatic int find_slot(longint v, int n);
      int s;
      s = 0;
      while (s < n && v > tbl_x[s]) s++;
      return s;
   endfunction

   function automatic longint predict_point(longint v, int n);
      int          s;
      longint      dx, ofs, dy;
      logic [63:0] mag;
      s = find_slot(v, n);
      if (s == 0) return tbl_y[0];
      if (s == n) return tbl_y[n-1];
      if (v == tbl_x[s]) return tbl_y[s];
      dx  = tbl_x[s] - tbl_x[s-1];
      ofs = v - tbl_x[s-1];
      dy  = tbl_y[s] - tbl_y[s-1];
      // multiply first, then truncating unsigned divide on magnitudes
      mag = $unsigned(dy < 0 ? -dy : dy) * $unsigned(ofs) / $unsigned(dx);
      return (dy < 0) ? tbl_y[s-1] - longint'(mag) : tbl_y[s-1] + longint'(mag);
   endfunction

   // sum of doubled trapezoids, halved toward zero, saturated to 64 bits
   function automatic logic [63:0] predict_area(longint v1, longint v2, int n);
      int                  s1, s2;
      longint              xs, xe;
      logic signed [127:0] acc, wd, ht, mag;
      s1  = find_slot(v1, n);
      s2  = find_slot(v2, n);
      acc = '0;
      for (int s = s1; s <= s2; s++) begin
         xs = v1;
         xe = v2;
         if (s > 0 && tbl_x[s-1] > v1) xs = tbl_x[s-1];
         if (s < n && tbl_x[s] < v2) xe = tbl_x[s];
         wd  = xe - xs;
         ht  = predict_point(xe, n) + predict_point(xs, n);
         acc = acc + wd * ht;
      end
      mag = (acc < 0) ? -acc : acc;
      mag = mag >>> 1;
      if (acc < 0) begin
         if (mag > 128'sh8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
         return -mag[63:0];
      end
      if (mag > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
      return mag[63:0];
   endfunction

   // apply one accepted item to the mirror; returns 1 when it yields a result
   function automatic bit predict_item(logic [1:0] op, logic [3:0] idx, int px, int py,
                                       int qs, int qe, output result_type r);
      int n;
      n = used_points();
      r = '{value: '0, empty_err: 1'b0};
      if (op == OP_LOAD) begin
         tbl_x[idx] = px;
         tbl_y[idx] = py;
         return 1'b0;
      end
      if (op == OP_NONE) return 1'b0;
      if (n == 0) begin
         r.empty_err = 1'b1;
         return 1'b1;
      end
      if (op == OP_EVALUATE) r.value = predict_point(qs, n);
      else r.value = predict_area(qs, qe, n);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic send_item(logic [1:0] op, logic [3:0] idx, int px, int py, int qs, int qe,
                            bit typed = 1'b0, logic [63:0] t_val = '0, logic t_err = 1'b0);
      int         gap;
      result_type r;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_point_index <= idx;
      req_point_x     <= px;
      req_point_y     <= py;
      req_query_start <= qs;
      req_query_end   <= qe;
      do @(posedge clock); while (!req_ready);
      // transfer happened at this edge
      if (predict_item(op, idx, px, py, qs, qe, r)) begin
         if (typed) r = '{value: t_val, empty_err: t_err};
         pending_results.insert(pending_results.size(), r);
      end
   endtask

   // drop valid, wait for every result, then let a trailing load finish
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_count(logic [4:0] cnt);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cnt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      point_count_m = cnt;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall per transfer, compare with oldest expectation
   // ---------------------------------------------------------------------
   int rsp_wait = 0;

   always @(posedge clock) begin
      int         w;
      result_type e;
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result value=%h err=%b", rsp_result_value,
                   rsp_empty_table_error);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_value !== e.value) begin
               $error("result_value expected %h actual %h", e.value, rsp_result_value);
               fail_count++;
            end
            if (rsp_empty_table_error !== e.empty_err) begin
               $error("empty_table_error expected %b actual %b", e.empty_err,
                      rsp_empty_table_error);
               fail_count++;
            end
         end
         w = quiet ? 0 : $urandom_range(0, 13);
         rsp_wait  <= w;
         rsp_ready <= (w == 0);
      end else if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: cycles with no transfer on either channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   typedef struct {
      bit          cfg;     // write point_count = px instead of sending an item
      logic [1:0]  op;
      logic [3:0]  idx;
      int          px, py, qs, qe;
      bit          typed;
      logic [63:0] t_val;
      logic        t_err;
   } row_type;

   function automatic int dir_x(int i);
      return -32'sh7000_0000 + i * 32'sh0E00_0000;
   endfunction

   // alternating full-scale ordinates
   function automatic int dir_y(int i);
      return (i % 2 == 0) ? 32'sh7FFF_FFFF - i : -32'sh8000_0000 + i;
   endfunction

   function automatic void add_row(ref row_type q[$], input bit cfg, logic [1:0] op,
                                   logic [3:0] idx, int px, int py, int qs, int qe,
                                   bit typed, logic [63:0] t_val, logic t_err);
      q.insert(q.size(), '{cfg, op, idx, px, py, qs, qe, typed, t_val, t_err});
   endfunction

   // ascending random table, sometimes clustered, sometimes left unordered
   task automatic load_random_table();
      int xs [NPTS];
      int span;
      span = $urandom_range(0, 2);
      foreach (xs[i]) begin
         xs[i] = $urandom();
         if (span == 1) xs[i] = $signed(xs[i]) >>> 20;
      end
      if ($urandom_range(0, 7) != 0) xs.sort();
      for (int i = 0; i < NPTS; i++)
         send_item(OP_LOAD, 4'(i), xs[i], int'($urandom()), int'($urandom()), int'($urandom()));
   endtask

   function automatic int pick_query();
      int k;
      k = $urandom_range(0, NPTS - 1);
      case ($urandom_range(0, 5))
         0: return int'(tbl_x[k]);
         1: return int'(tbl_x[k]) + $signed($urandom_range(0, 4)) - 2;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
         default: return int'($urandom());
      endcase
   endfunction

   initial begin
      row_type     rows [$];
      logic [1:0]  op;
      logic [4:0]  cnt;
      int          k, nq;

      // after reset the table is empty
      add_row(rows, 0, OP_EVALUATE,  0, 0, 0, 0, 0, 1, 64'd0, 1'b1);
      add_row(rows, 0, OP_INTEGRATE, 0, 0, 0, -32'sh8000_0000, 32'sh7FFF_FFFF,
              1, 64'd0, 1'b1);
      add_row(rows, 0, OP_NONE, 0, 0, 0, 0, 0, 0, '0, 0);
      for (int i = 0; i < NPTS; i++)
         add_row(rows, 0, OP_LOAD, 4'(i), dir_x(i), dir_y(i), 0, 0, 0, '0, 0);
      add_row(rows, 1, OP_NONE, 0, NPTS, 0, 0, 0, 0, '0, 0);
      // clamp below first and above last, exact hit
      add_row(rows, 0, OP_EVALUATE, 0, 0, 0, -32'sh8000_0000, 0,
              1, 64'(longint'(dir_y(0))), 1'b0);
      add_row(rows, 0, OP_EVALUATE, 0, 0, 0, 32'sh7FFF_FFFF, 0,
              1, 64'(longint'(dir_y(NPTS - 1))), 1'b0);
      add_row(rows, 0, OP_EVALUATE, 0, 0, 0, dir_x(5), 0, 1, 64'(longint'(dir_y(5))), 1'b0);
      add_row(rows, 0, OP_EVALUATE, 0, 0, 0, dir_x(3) + 32'sh0123_4567, 0, 0, '0, 0);
      add_row(rows, 0, OP_INTEGRATE, 0, 0, 0, -32'sh8000_0000, 32'sh7FFF_FFFF, 0, '0, 0);
      add_row(rows, 0, OP_INTEGRATE, 0, 0, 0, dir_x(9), dir_x(2) + 1, 0, '0, 0);
      add_row(rows, 0, OP_INTEGRATE, 0, 0, 0, dir_x(7) + 5, dir_x(8) - 5, 0, '0, 0);

      point_count_m = '0;
      foreach (tbl_x[i]) begin
         tbl_x[i] = 0;
         tbl_y[i] = 0;
      end

      // synchronous reset
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].cfg)
            write_count(5'(rows[i].px));
         else
            send_item(rows[i].op, rows[i].idx, rows[i].px, rows[i].py, rows[i].qs,
                      rows[i].qe, rows[i].typed, rows[i].t_val, rows[i].t_err);
      end

      // random phases: new count and a fresh table, then queries against it
      for (int ph = 0; ph < 21; ph++) begin
         case (ph)
            0: cnt = 5'd31;
            1: cnt = 5'd0;
            2: cnt = 5'd1;
            3: cnt = 5'd16;
            4: cnt = 5'd2;
            default: cnt = 5'($urandom_range(0, 31));
         endcase
         write_count(cnt);
         quiet = ($urandom_range(0, 3) == 0);
         load_random_table();
         nq = $urandom_range(30, 44);
         for (int j = 0; j < nq; j++) begin
            k = $urandom_range(0, 19);
            // a stray load overwrites its slot; the predictor mirrors it
            op = (k < 9) ? OP_EVALUATE : (k < 18) ? OP_INTEGRATE : (k < 19) ? OP_NONE : OP_LOAD;
            send_item(op, 4'($urandom()), int'($urandom()), int'($urandom()),
                      pick_query(), pick_query());
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
